// ===== rtl/core/sdes8_pkg.sv =====
`default_nettype none

package sdes8_pkg;

    // Number of Feistel rounds, one round cell each.
    localparam int ROUNDS_DEF = 16;

    // Configuration port geometry: one 32-bit register, word index in paddr[2].
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_CIPHER_KEY = 1'b0;

    // Direction codes carried in tuser.
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // DES S-box 1, nibble {row, col} at bits [4*{row,col} +: 4].
    localparam logic [255:0] SBOX1 = {
        64'hD60A_E3B5_7194_28CF,
        64'h05A3_79CF_B26D_8E14,
        64'h8359_BC6A_1D2E_47F0,
        64'h7095_C6A3_8BF2_1D4E
    };

    // Per-round left rotation of the key nibbles, entry i at bits [2*i +: 2].
    localparam logic [31:0] ROT_SCHED = {
        2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1
    };

    // Data moving along the chain of round cells.
    typedef struct packed {
        logic       valid;
        logic       cmd;
        logic [3:0] left;
        logic [3:0] right;
    } stage_t;

    // Rotate a nibble left by sh positions.
    function automatic logic [3:0] rotl4(input logic [3:0] v, input logic [1:0] sh);
        logic [7:0] dbl;
        dbl = {v, v} << sh;
        return dbl[7:4];
    endfunction

    // Cumulative rotation of the key nibbles before round idx, modulo four.
    function automatic logic [1:0] cum_shift(input logic [3:0] idx);
        logic [1:0] acc;
        acc = 2'd0;
        for (int i = 0; i < 16; i++) begin
            if (4'(i) <= idx) begin
                acc = acc + ROT_SCHED[2*i +: 2];
            end
        end
        return acc;
    endfunction

    // Round key idx from the master key.
    function automatic logic [5:0] round_key(input logic [7:0] key, input logic [3:0] idx);
        logic [7:0] k;
        logic [3:0] c;
        logic [3:0] d;
        logic [5:0] cd;
        logic [5:0] rev;
        k   = {key[6:0], key[7]};
        c   = rotl4(k[7:4], cum_shift(idx));
        d   = rotl4(k[3:0], cum_shift(idx));
        cd  = {c[2:0], d[2:0]};
        for (int i = 0; i < 6; i++) begin
            rev[5-i] = cd[i];
        end
        return rev;
    endfunction

    // Round function: expansion, key mix, S-box, rotate.
    function automatic logic [3:0] round_f(input logic [3:0] r, input logic [5:0] k);
        logic [5:0] x;
        logic [5:0] idx;
        x   = {r[0], r[3], r[2], r[1], r[0], r[2]} ^ k;
        idx = {x[5], x[0], x[4:1]};
        return rotl4(SBOX1[{idx, 2'b00} +: 4], 2'd1);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sdes8_key_sched.sv =====
`default_nettype none

module sdes8_key_sched
    import sdes8_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  wire logic [7:0]              cipher_key,
    output logic      [ROUNDS-1:0][5:0]  key_enc,
    output logic      [ROUNDS-1:0][5:0]  key_dec
);

    // Each cell position gets its forward key and the mirrored key for decryption.
    for (genvar i = 0; i < ROUNDS; i++) begin : g_key
        assign key_enc[i] = round_key(cipher_key, 4'(i));
        assign key_dec[i] = round_key(cipher_key, 4'(ROUNDS - 1 - i));
    end

endmodule

`default_nettype wire

// ===== rtl/core/sdes8_round_cell.sv =====
`default_nettype none

module sdes8_round_cell
    import sdes8_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       advance,
    input  wire logic [5:0] key_enc,
    input  wire logic [5:0] key_dec,
    input  wire stage_t     stage_in,
    output stage_t          stage_out
);

    logic       valid_reg;
    logic       cmd_reg;
    logic [3:0] left_reg;
    logic [3:0] right_reg;
    logic [5:0] key_sel;
    logic [3:0] right_next;

    // One Feistel round on the item entering this cell.
    assign key_sel    = (stage_in.cmd == CMD_DECRYPT) ? key_dec : key_enc;
    assign right_next = stage_in.left ^ round_f(stage_in.right, key_sel);

    // Valid flag follows the chain and is cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= stage_in.valid;
        end
    end

    // Payload moves with the chain.
    always_ff @(posedge aclk) begin
        if (advance) begin
            cmd_reg   <= stage_in.cmd;
            left_reg  <= stage_in.right;
            right_reg <= right_next;
        end
    end

    assign stage_out = '{valid: valid_reg, cmd: cmd_reg, left: left_reg, right: right_reg};

endmodule

`default_nettype wire

// ===== rtl/core/mini_des_8bit_block_cipher.sv =====
`default_nettype none

// Channel   Direction  tdata            tuser        Notes
// s_ (in)   input      [7:0] data_in    [0] cmd      high nibble is the left half
// m_ (out)  output     [7:0] data_out   none         halves swapped after last round
// APB       config     cipher_key at byte address 0, 32-bit data
//
// Each item passes through ROUNDS round cells, one round per cell, each cell
// registered; a new item is taken every cycle unless the chain holds.
// The last cell is the output register. When it holds an item that is not taken,
// the whole chain holds and s_tready drops. Reset is synchronous and clears the
// valid flags of all cells and the key register.

module mini_des_8bit_block_cipher
    import sdes8_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] data_in
    input  wire logic              s_tuser,   // [0] cmd

    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [7:0]        m_tdata,   // [7:0] data_out

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    logic [7:0]             cipher_key_reg;
    logic [ROUNDS-1:0][5:0] key_enc;
    logic [ROUNDS-1:0][5:0] key_dec;
    stage_t                 chain [ROUNDS+1];
    logic                   advance;

    // Configuration register write and readback.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cipher_key_reg <= 8'd0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_CIPHER_KEY) begin
            cipher_key_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_CIPHER_KEY) ? {{(DATA_W-8){1'b0}}, cipher_key_reg}
                                                 : '0;

    // Round keys for every cell position.
    sdes8_key_sched #(
        .ROUNDS(ROUNDS)
    ) u_key_sched (
        .cipher_key (cipher_key_reg),
        .key_enc    (key_enc),
        .key_dec    (key_dec)
    );

    // The chain moves unless the last cell holds an item that is not taken.
    assign advance  = !chain[ROUNDS].valid || m_tready;
    assign s_tready = advance;

    assign chain[0] = '{valid: s_tvalid, cmd: s_tuser, left: s_tdata[7:4],
                        right: s_tdata[3:0]};

    for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
        sdes8_round_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .key_enc   (key_enc[i]),
            .key_dec   (key_dec[i]),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    // Result is the final halves swapped.
    assign m_tvalid = chain[ROUNDS].valid;
    assign m_tdata  = {chain[ROUNDS].right, chain[ROUNDS].left};

endmodule

`default_nettype wire

// ===== dv/sdes8_checker.sv =====
`timescale 1ns / 1ps

// Watches the item channels and the register port of the cipher, works out
// the expected output byte for every accepted input item and compares it
// with the byte that comes out, in order.
module sdes8_checker
    import sdes8_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] data_in
    input  wire logic              s_tuser,   // [0] cmd

    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [7:0]        m_tdata,   // [7:0] data_out

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    input  wire logic [DATA_W-1:0] prdata,
    input  wire logic              pready,

    output int                     fail_count,
    output int                     outstanding
);

    localparam int NUM_ROUNDS = ROUNDS_DEF;

    // One accepted item together with the byte it must produce.
    typedef struct packed {
        logic [7:0] data_in;
        logic       cmd;
        logic [7:0] key;
        logic [7:0] data_out;
    } cipher_job_t;

    cipher_job_t pending_bytes[$];
    logic [7:0]  key_shadow;
    int          errs;

    // Left rotation of the key halves before each round.
    function automatic int shift_for_round(input int rnd);
        return (rnd == 0 || rnd == 1 || rnd == 8 || rnd == 15) ? 1 : 2;
    endfunction

    // First DES S-box; each row holds entry 0 in its lowest nibble.
    function automatic logic [3:0] s1_lookup(input logic [1:0] row, input logic [3:0] col);
        logic [63:0] row_bits;
        case (row)
            2'd0: row_bits = 64'h7095_C6A3_8BF2_1D4E;
            2'd1: row_bits = 64'h8359_BC6A_1D2E_47F0;
            2'd2: row_bits = 64'h05A3_79CF_B26D_8E14;
            default: row_bits = 64'hD60A_E3B5_7194_28CF;
        endcase
        return row_bits[4*col +: 4];
    endfunction

    // Full encryption or decryption of one byte under the given key.
    function automatic logic [7:0] sdes_predict(input logic [7:0] key, input logic decrypt,
                                                input logic [7:0] din);
        logic [95:0] subkeys;
        logic [7:0]  rotated;
        logic [3:0]  c_half;
        logic [3:0]  d_half;
        logic [5:0]  cd;
        logic [5:0]  rkey;
        logic [5:0]  mixed;
        logic [3:0]  lh;
        logic [3:0]  rh;
        logic [3:0]  nh;
        logic [3:0]  sv;
        int          idx;

        // Key schedule: the rotation of the halves accumulates over the rounds.
        rotated = {key[6:0], key[7]};
        c_half  = rotated[7:4];
        d_half  = rotated[3:0];
        for (int i = 0; i < NUM_ROUNDS; i++) begin
            for (int j = 0; j < shift_for_round(i); j++) begin
                c_half = {c_half[2:0], c_half[3]};
                d_half = {d_half[2:0], d_half[3]};
            end
            cd = {c_half[2:0], d_half[2:0]};
            for (int j = 0; j < 6; j++) begin
                rkey[5-j] = cd[j];
            end
            subkeys[6*i +: 6] = rkey;
        end

        // Feistel network; decryption walks the subkeys backward.
        lh = din[7:4];
        rh = din[3:0];
        for (int i = 0; i < NUM_ROUNDS; i++) begin
            idx   = decrypt ? NUM_ROUNDS - 1 - i : i;
            mixed = {rh[0], rh[3], rh[2], rh[1], rh[0], rh[2]} ^ subkeys[6*idx +: 6];
            sv    = s1_lookup({mixed[5], mixed[0]}, mixed[4:1]);
            nh    = lh ^ {sv[2:0], sv[3]};
            lh    = rh;
            rh    = nh;
        end
        return {rh, lh};
    endfunction

    initial begin
        errs = 0;
        key_shadow = 8'h00;
    end

    always @(posedge aclk) begin : monitor
        cipher_job_t job;
        if (!aresetn) begin
            key_shadow = 8'h00;
            pending_bytes.delete();
        end else begin
            // Register port: track writes, check read data against the shadow.
            if (psel && penable && pready && paddr[ADDR_W-1:2] == REG_CIPHER_KEY) begin
                if (pwrite) begin
                    key_shadow = pwdata[7:0];
                end else if (prdata[7:0] !== key_shadow) begin
                    errs++;
                    $display("%0t: cipher_key readback mismatch: expected %02h, actual %02h",
                             $time, key_shadow, prdata[7:0]);
                end
            end

            // Each accepted item gets its expected byte at once.
            if (s_tvalid && s_tready) begin
                job.data_in  = s_tdata;
                job.cmd      = s_tuser;
                job.key      = key_shadow;
                job.data_out = sdes_predict(key_shadow, s_tuser == CMD_DECRYPT, s_tdata);
                pending_bytes.push_back(job);
            end

            // Results come back in order.
            if (m_tvalid && m_tready) begin
                if (pending_bytes.size() == 0) begin
                    errs++;
                    $display("%0t: unexpected result: expected none, actual %02h",
                             $time, m_tdata);
                end else begin
                    job = pending_bytes.pop_front();
                    if (m_tdata !== job.data_out) begin
                        errs++;
                        $display("%0t: data_out mismatch: expected %02h, actual %02h (data_in %02h, cmd %0d, key %02h)",
                                 $time, job.data_out, m_tdata, job.data_in, job.cmd, job.key);
                    end
                end
            end
        end
        fail_count  <= errs;
        outstanding <= pending_bytes.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import sdes8_pkg::*;

    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 117;
    localparam int HOLD_CYCLES      = 300;
    localparam int CYCLE_LIMIT      = 200000;
    localparam logic [ADDR_W-1:0] KEY_ADDR   = {REG_CIPHER_KEY, 2'b00};
    localparam logic [ADDR_W-1:0] SPARE_ADDR = {~REG_CIPHER_KEY, 2'b00};

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;

    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = 8'h00;   // [7:0] data_in
    logic              s_tuser  = 1'b0;    // [0] cmd

    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;            // [7:0] data_out

    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [DATA_W-1:0] pwdata   = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int tx_idle_pct = 30;
    int rx_idle_pct = 30;
    bit hold_req    = 1'b0;

    always #2 aclk = ~aclk;

    mini_des_8bit_block_cipher uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    sdes8_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL mini_des_8bit_block_cipher");
            $finish;
        end
    end

    // One register access: setup cycle, access cycle, then a bus idle cycle.
    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Write the key and read it back so the checker can compare.
    task automatic set_key(input logic [DATA_W-1:0] value);
        apb_access(1'b1, KEY_ADDR, value);
        apb_access(1'b0, KEY_ADDR, '0);
    endtask

    // Offer one item, possibly after a short gap, and wait until it is taken.
    task automatic send_byte(input logic cmd, input logic [7:0] data);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop offering and wait until every expected byte has come out.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Receiver: random ready bursts, plus one long hold-off on request.
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        logic [7:0] key_val;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset key is zero; check it by reading before any write.
        apb_access(1'b0, KEY_ADDR, '0);
        send_byte(CMD_ENCRYPT, 8'h00);
        send_byte(CMD_DECRYPT, 8'h00);
        send_byte(CMD_ENCRYPT, 8'hFF);
        send_byte(CMD_DECRYPT, 8'hFF);
        send_byte(CMD_ENCRYPT, 8'h0F);
        send_byte(CMD_DECRYPT, 8'hF0);
        drain();

        // All-ones key.
        set_key(32'h0000_00FF);
        send_byte(CMD_ENCRYPT, 8'h00);
        send_byte(CMD_ENCRYPT, 8'hFF);
        send_byte(CMD_DECRYPT, 8'h5A);
        send_byte(CMD_DECRYPT, 8'hA5);
        drain();

        // Only the low byte of the write data is the key.
        set_key(32'hA5A5_5A01);
        send_byte(CMD_ENCRYPT, 8'h3C);
        send_byte(CMD_DECRYPT, 8'hC3);
        drain();

        // A write outside the register map must leave the key alone.
        apb_access(1'b1, SPARE_ADDR, 32'h0000_0077);
        apb_access(1'b0, KEY_ADDR, '0);
        send_byte(CMD_ENCRYPT, 8'h81);
        send_byte(CMD_DECRYPT, 8'h7E);
        drain();

        // Top key bit alone wraps around in the first key rotation.
        set_key(32'h0000_0080);
        send_byte(CMD_ENCRYPT, 8'h01);
        send_byte(CMD_DECRYPT, 8'h80);
        drain();

        // Random phases, each under its own key and idling mix.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0) begin
                key_val = 8'h00;
            end else if (ph == 1) begin
                key_val = 8'hFF;
            end else begin
                key_val = 8'($urandom_range(0, 255));
            end
            set_key({24'($urandom()), key_val});

            tx_idle_pct = (ph % 3 == 2) ? 0 : 30;
            rx_idle_pct = (ph % 4 == 2) ? 0 : 30;
            if (ph == 3) begin
                // Keep offering while the output is held so the pipeline backs up.
                tx_idle_pct = 5;
                hold_req = 1'b1;
            end
            if (ph == RANDOM_PHASES - 1) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            repeat (ITEMS_PER_PHASE) begin
                send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            drain();
        end

        repeat (ROUNDS_DEF + 4) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("PASS mini_des_8bit_block_cipher");
        end else begin
            $display("FAIL mini_des_8bit_block_cipher");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/sdes8_pkg.sv
rtl/core/sdes8_key_sched.sv
rtl/core/sdes8_round_cell.sv
rtl/core/mini_des_8bit_block_cipher.sv
dv/sdes8_checker.sv
dv/tb_top.sv
